/* hw/rtl/sobel_horizontal_edge_filter_unit_defines.svh */
// Assertion macros for the Sobel horizontal edge filter checker.
// Stand-alone header: no dependencies.
`ifndef SOBEL_HORIZONTAL_EDGE_FILTER_UNIT_DEFINES_SVH
`define SOBEL_HORIZONTAL_EDGE_FILTER_UNIT_DEFINES_SVH

// Property checked outside of reset.
`define SOBEL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define SOBEL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sobel_pkg.sv */
// Shared types and constants for the Sobel horizontal edge filter.
// No dependencies; used by the channel interfaces and the top level.
package sobel_pkg;

    localparam int unsigned PIXEL_W       = 8;
    localparam int unsigned LINE_WIDTH_W  = 11;
    localparam int unsigned FRAME_LINES_W = 13;
    localparam int unsigned LINE_COUNT_W  = 12;
    localparam int unsigned CFG_DATA_W    = 13;
    localparam int unsigned CFG_IDX_W     = 2;

    typedef logic [PIXEL_W-1:0]       t_pixel;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]    t_cfg_data;
    typedef logic [LINE_WIDTH_W-1:0]  t_line_width;
    typedef logic [FRAME_LINES_W-1:0] t_frame_lines;
    typedef logic [LINE_COUNT_W-1:0]  t_line_count;

    // Register indexes on the configuration port
    localparam t_cfg_idx CFG_LINE_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_FRAME_LINES = 2'd1;

    localparam t_line_width  LINE_WIDTH_RESET  = 11'd640;
    localparam t_frame_lines FRAME_LINES_RESET = 13'd480;

    localparam t_line_width  MIN_LINE_WIDTH  = 11'd3;
    localparam t_frame_lines MIN_FRAME_LINES = 13'd3;
    localparam t_frame_lines MAX_FRAME_LINES = 13'd4096;

    localparam t_pixel PIXEL_MAX = 8'd255;

endpackage

/* hw/rtl/sobel_if.sv */
// Valid/ready channel interfaces for the Sobel horizontal edge filter:
// input pixel requests and filter result requests. Depends on sobel_pkg.
interface sobel_pix_if;
    import sobel_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sobel_res_if;
    import sobel_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel edge_value;
    logic   line_end;
    logic   frame_end;

    modport source (output valid, output edge_value, output line_end, output frame_end,
                    input ready);
    modport sink   (input valid, input edge_value, input line_end, input frame_end,
                    output ready);
endinterface

/* hw/rtl/sobel_horizontal_edge_filter_unit.sv */
// Sobel horizontal edge filter: two line memories, a 3x3 window, one result register.
// Depends on sobel_pkg and the channel interfaces in sobel_if.sv.
//
// Usage:
//   i_pix carries grayscale pixels in raster order, one request per pixel.
//   o_res carries one request per full 3x3 window: the clamped response
//   (top row 1,2,1 minus bottom row 1,2,1), with line_end on the last result
//   of an output line and frame_end on the last result of the frame.
//   The first two lines and the first two pixels of every line give no result.
//   Configuration (line_width, frame_lines) is written through i_cfg_* while idle.
// Timing:
//   One pixel per cycle while no result waits on a stalled receiver. A result
//   enters the result register at the edge that accepts its pixel. The line
//   memories are read ahead at the next column, so the single write/read port
//   pair of each memory and the one-entry result register set the rate.
// Reset:
//   Counters, window and result valid clear; registers return to 640 x 480.
//   Line memories are not cleared: no result uses a location before it is written.
// Stall:
//   While a result waits on a stalled receiver, i_pix.ready drops; it is high
//   whenever the result register is empty or being taken in the same cycle.
module sobel_horizontal_edge_filter_unit #(
    parameter int unsigned MAX_LINE_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  sobel_pkg::t_cfg_idx   i_cfg_idx,
    input  sobel_pkg::t_cfg_data  i_cfg_data,
    sobel_pix_if.sink             i_pix,
    sobel_res_if.source           o_res
);
    import sobel_pkg::*;

    localparam int unsigned CW   = $clog2(MAX_LINE_WIDTH);
    localparam int unsigned CMPW = (CW >= LINE_WIDTH_W) ? CW + 1 : LINE_WIDTH_W + 1;

    localparam logic [CMPW-1:0] MAX_W_CMP = CMPW'(MAX_LINE_WIDTH);
    localparam logic [CMPW-1:0] MIN_W_CMP = CMPW'(MIN_LINE_WIDTH);

    t_line_width  r_line_width;
    t_frame_lines r_frame_lines;

    logic [CW-1:0] r_col, n_col;
    t_line_count   r_row, n_row;

    // window columns: index 0 is the older column; [0] top, [1] middle, [2] bottom
    t_pixel r_win0 [3];
    t_pixel r_win1 [3];

    t_pixel r_upper_mem  [MAX_LINE_WIDTH];
    t_pixel r_middle_mem [MAX_LINE_WIDTH];
    t_pixel r_upper_rd;
    t_pixel r_middle_rd;

    logic   r_out_valid;
    t_pixel r_edge_value;
    logic   r_line_end;
    logic   r_frame_end;

    logic            in_ready;
    logic            accept;
    logic [CMPW-1:0] lw_cmp;
    logic [CMPW-1:0] eff_w;
    t_frame_lines    eff_h;
    logic            last_col;
    logic            last_row;
    logic            emit;
    logic [9:0]      top_sum;
    logic [9:0]      bot_sum;
    logic signed [10:0] diff;
    t_pixel          edge_val;

    assign in_ready    = !r_out_valid || o_res.ready;
    assign accept      = i_pix.valid && in_ready;
    assign i_pix.ready = in_ready;

    // clamp the configured sizes to their legal ranges
    always_comb begin
        lw_cmp = CMPW'(r_line_width);
        priority if (lw_cmp < MIN_W_CMP) begin
            eff_w = MIN_W_CMP;
        end else if (lw_cmp > MAX_W_CMP) begin
            eff_w = MAX_W_CMP;
        end else begin
            eff_w = lw_cmp;
        end
        priority if (r_frame_lines < MIN_FRAME_LINES) begin
            eff_h = MIN_FRAME_LINES;
        end else if (r_frame_lines > MAX_FRAME_LINES) begin
            eff_h = MAX_FRAME_LINES;
        end else begin
            eff_h = r_frame_lines;
        end
    end

    assign last_col = CMPW'(r_col) >= (eff_w - CMPW'(1));
    assign last_row = {1'b0, r_row} >= (eff_h - FRAME_LINES_W'(1));
    assign emit     = (r_row >= LINE_COUNT_W'(2)) && (CMPW'(r_col) >= CMPW'(2));

    always_comb begin
        top_sum = {2'b00, r_win0[0]} + {1'b0, r_win1[0], 1'b0} + {2'b00, r_upper_rd};
        bot_sum = {2'b00, r_win0[2]} + {1'b0, r_win1[2], 1'b0} + {2'b00, i_pix.pixel};
        diff    = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
        priority if (diff < 0) begin
            edge_val = '0;
        end else if (diff > 11'sd255) begin
            edge_val = PIXEL_MAX;
        end else begin
            edge_val = diff[7:0];
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + LINE_COUNT_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width  <= LINE_WIDTH_RESET;
            r_frame_lines <= FRAME_LINES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_WIDTH:  r_line_width  <= i_cfg_data[LINE_WIDTH_W-1:0];
                CFG_FRAME_LINES: r_frame_lines <= i_cfg_data[FRAME_LINES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            for (int k = 0; k < 3; k++) begin
                r_win0[k] <= '0;
                r_win1[k] <= '0;
            end
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_win0    <= r_win1;
                r_win1[0] <= r_upper_rd;
                r_win1[1] <= r_middle_rd;
                r_win1[2] <= i_pix.pixel;
            end
        end
    end

    // read ahead at the next column so the data is ready when its pixel arrives
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_upper_mem[r_col]  <= r_middle_rd;
            r_middle_mem[r_col] <= i_pix.pixel;
        end
        r_upper_rd  <= r_upper_mem[n_col];
        r_middle_rd <= r_middle_mem[n_col];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_ready) begin
            r_out_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_edge_value <= edge_val;
            r_line_end   <= last_col;
            r_frame_end  <= last_col && last_row;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.edge_value = r_edge_value;
    assign o_res.line_end   = r_line_end;
    assign o_res.frame_end  = r_frame_end;

endmodule

/* hw/rtl/sobel_chk.sv */
// Port-level checker for the Sobel horizontal edge filter, bound to the top level.
// Depends on sobel_pkg and sobel_horizontal_edge_filter_unit_defines.svh.
`include "sobel_horizontal_edge_filter_unit_defines.svh"

module sobel_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_pix_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input sobel_pkg::t_pixel i_res_edge_value,
    input logic              i_res_line_end,
    input logic              i_res_frame_end
);
    import sobel_pkg::*;

    // reset empties the result register
    `SOBEL_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_res_valid, "result valid after reset")

    // a stalled result request holds its payload
    `SOBEL_ASSERT(a_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_edge_value) && $stable(i_res_line_end) && $stable(i_res_frame_end), "stalled result changed")

    // frame end only on a line end
    `SOBEL_ASSERT(a_frame_on_line, i_clk, i_rst_n, i_res_valid |-> (!i_res_frame_end || i_res_line_end), "frame_end without line_end")

    // an empty or draining result register never blocks the input
    `SOBEL_ASSERT(a_ready_free, i_clk, i_rst_n, (!i_res_valid || i_res_ready) |-> i_pix_ready, "input blocked while output free")

endmodule

bind sobel_horizontal_edge_filter_unit sobel_chk u_sobel_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_pix_ready      (i_pix.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_edge_value (o_res.edge_value),
    .i_res_line_end   (o_res.line_end),
    .i_res_frame_end  (o_res.frame_end)
);
